// File: hw/rtl/bwtlf_pkg.sv
// Package for the run-length LF index block: request/result structs, modes, status codes.
// No dependencies.
package bwtlf_pkg;

  localparam int FW = 13;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QIDX  = 2'd1;
  localparam logic [1:0] MODE_QPOS  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic [1:0]    mode;
    logic [7:0]    symbol;
    logic [FW-1:0] operand;
  } req_t;

  typedef struct packed {
    logic [FW-1:0] run_index;
    logic [FW-1:0] run_start;
    logic [FW-1:0] lf_value;
    logic [1:0]    status;
  } rsp_t;

endpackage

// File: hw/rtl/bwtlf_cmp.sv
// Shared compare/add unit used by the count, prefix-sum, run, query and search steps.
// Depends on bwtlf_pkg.
module bwtlf_cmp import bwtlf_pkg::*; (
  input  logic [FW:0] a,
  input  logic [FW:0] b,
  output logic        le,
  output logic [FW:0] sum
);
  assign le  = (a <= b);
  assign sum = a + b;
endmodule

// File: hw/rtl/bwt_run_lf_index_core.sv
// Top level of the run-length LF index: store, tables, build and query sequencer.
// Depends on bwtlf_pkg and bwtlf_cmp.
//
// Usage: requests arrive on in_valid/in_stall with an req_t payload; results leave on
// out_valid/out_stall as rsp_t, one result per request, in order. The primary index
// register is written on cfg_valid/cfg_ready (ready while idle, with no result pending
// and no request offered).
// Sequence: a load or clear goes straight to the output state; an index query checks its
// operand and reads the run tables; a position query binary-searches the run starts (one
// table read per search step on the single read port) and then reads the tables. The first
// query after a stored load, a clear or a config write first runs a build: clear the counts,
// count the symbols, form prefix sums, and form the runs. One request is in work at a time;
// in_stall is high from acceptance until the result is taken.
// Reset clears length, run count, primary index and the built flag; stores need no
// clearing. While out_stall is high the result holds and no new request is taken.
module bwt_run_lf_index_core import bwtlf_pkg::*; #(
  parameter int MAX_LENGTH    = 4096,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  req_t          in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rsp_t          out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [FW-1:0] cfg_data
);

  localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int TD = MAX_LENGTH + 2;
  localparam int TW = $clog2(TD);
  localparam int SW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int LW = $clog2(MAX_LENGTH + 1);
  localparam int CW = $clog2(TD + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_CNTR  = 4'd2;
  localparam logic [3:0] S_CNTW  = 4'd3;
  localparam logic [3:0] S_PFX   = 4'd4;
  localparam logic [3:0] S_RUNR  = 4'd5;
  localparam logic [3:0] S_RUNW  = 4'd6;
  localparam logic [3:0] S_QRY   = 4'd7;
  localparam logic [3:0] S_SRCH  = 4'd8;
  localparam logic [3:0] S_SCMP  = 4'd9;
  localparam logic [3:0] S_FETCH = 4'd10;
  localparam logic [3:0] S_FOUT  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_PFXR  = 4'd13;
  localparam logic [3:0] S_CNTW2 = 4'd14;
  localparam logic [3:0] S_RUNC  = 4'd15;

  logic [3:0]    state;
  req_t          req;
  rsp_t          rsp;
  logic [FW-1:0] prim;
  logic [LW-1:0] len;
  logic [CW-1:0] nruns;
  logic          built;

  // memories
  logic [7:0]    sym_mem [MAX_LENGTH];
  logic [FW-1:0] cnt_mem [ALPHABET_SIZE];
  logic [FW-1:0] st_mem  [TD];
  logic [FW-1:0] lf_mem  [TD];
  logic [7:0]    sym_rd;
  logic [FW-1:0] cnt_rd;
  logic [FW-1:0] st_rd;
  logic [FW-1:0] lf_rd;

  // build / search counters
  logic [LW-1:0] pos;
  logic [SW:0]   sidx;
  logic [FW-1:0] acc;
  logic [FW-1:0] logical;
  logic [LW-1:0] pcut;
  logic          seg2;
  logic          have_prev;
  logic [7:0]    prev;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  logic [CW-1:0] mid_c;

  // shared unit
  logic [FW:0] ua, ub, usum;
  logic        ule;
  bwtlf_cmp u_cmp (.a(ua), .b(ub), .le(ule), .sum(usum));

  logic [LW-1:0] cut;
  assign cut   = seg2 ? len : pcut;
  assign mid_c = lo + ((hi - lo) >> 1);

  always_comb begin
    ua = '0;
    ub = '0;
    case (state)
      S_CNTW:  begin ua = {1'b0, cnt_rd}; ub = (FW+1)'(1); end
      S_PFX:   begin ua = {1'b0, acc}; ub = {1'b0, cnt_rd}; end
      S_RUNW:  begin ua = {1'b0, cnt_rd}; ub = (FW+1)'(1); end
      S_SCMP:  begin ua = {1'b0, st_rd}; ub = {1'b0, req.operand}; end
      S_QRY:   begin ua = (FW+1)'(req.operand) + (FW+1)'(1); ub = (FW+1)'(nruns); end
      default: begin ua = '0; ub = '0; end
    endcase
  end

  assign in_stall  = (state != S_IDLE) || out_valid;
  assign cfg_ready = (state == S_IDLE) && !out_valid && !in_valid;
  assign out_data  = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      prim      <= '0;
      len       <= '0;
      nruns     <= '0;
      built     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        prim  <= cfg_data;
        built <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req           <= in_data;
            rsp.run_index <= '0;
            rsp.run_start <= '0;
            rsp.lf_value  <= '0;
            rsp.status    <= (in_data.mode == MODE_LOAD && len == LW'(MAX_LENGTH)) ?
                             ST_OVERFLOW : ST_OK;
            case (in_data.mode)
              MODE_LOAD: begin
                if (len != LW'(MAX_LENGTH)) begin
                  sym_mem[len[AW-1:0]] <= (in_data.symbol > 8'(ALPHABET_SIZE - 1)) ?
                                          8'(ALPHABET_SIZE - 1) : in_data.symbol;
                  len   <= len + LW'(1);
                  built <= 1'b0;
                end
                state <= S_OUT;
              end
              MODE_CLEAR: begin
                len   <= '0;
                built <= 1'b0;
                state <= S_OUT;
              end
              default: begin
                if (built) begin
                  state <= S_QRY;
                end else begin
                  sidx  <= '0;
                  state <= S_CLR;
                end
              end
            endcase
          end
        end
        // zero the symbol counts
        S_CLR: begin
          cnt_mem[sidx[SW-1:0]] <= '0;
          sidx <= sidx + (SW+1)'(1);
          if (sidx == (SW+1)'(ALPHABET_SIZE - 1)) begin
            pos   <= '0;
            state <= S_CNTR;
          end
        end
        S_CNTR: begin
          if (pos == len) begin
            sidx  <= '0;
            acc   <= FW'(1);
            state <= S_PFXR;
          end else begin
            sym_rd <= sym_mem[pos[AW-1:0]];
            state  <= S_CNTW2;
          end
        end
        S_CNTW2: begin
          cnt_rd <= cnt_mem[sym_rd[SW-1:0]];
          state  <= S_CNTW;
        end
        S_CNTW: begin
          cnt_mem[sym_rd[SW-1:0]] <= usum[FW-1:0];
          pos   <= pos + LW'(1);
          state <= S_CNTR;
        end
        S_PFXR: begin
          cnt_rd <= cnt_mem[sidx[SW-1:0]];
          state  <= S_PFX;
        end
        // counts become start positions, starting at 1
        S_PFX: begin
          cnt_mem[sidx[SW-1:0]] <= acc;
          acc  <= usum[FW-1:0];
          sidx <= sidx + (SW+1)'(1);
          if (sidx == (SW+1)'(ALPHABET_SIZE - 1)) begin
            pos       <= '0;
            logical   <= '0;
            nruns     <= '0;
            seg2      <= 1'b0;
            have_prev <= 1'b0;
            pcut      <= ({{(FW+1-LW){1'b0}}, len} < {1'b0, prim}) ? len : LW'(prim);
            state     <= S_RUNR;
          end else begin
            state <= S_PFXR;
          end
        end
        S_RUNR: begin
          if (pos == cut) begin
            // terminator entry
            st_mem[nruns[TW-1:0]] <= logical;
            lf_mem[nruns[TW-1:0]] <= '0;
            nruns     <= nruns + CW'(1);
            logical   <= logical + FW'(1);
            have_prev <= 1'b0;
            if (seg2) begin
              built <= 1'b1;
              state <= S_QRY;
            end else begin
              seg2 <= 1'b1;
            end
          end else begin
            sym_rd <= sym_mem[pos[AW-1:0]];
            state  <= S_RUNC;
          end
        end
        S_RUNC: begin
          cnt_rd <= cnt_mem[sym_rd[SW-1:0]];
          state  <= S_RUNW;
        end
        S_RUNW: begin
          if (!have_prev || sym_rd != prev) begin
            st_mem[nruns[TW-1:0]] <= logical;
            lf_mem[nruns[TW-1:0]] <= cnt_rd;
            nruns <= nruns + CW'(1);
          end
          cnt_mem[sym_rd[SW-1:0]] <= usum[FW-1:0];
          prev      <= sym_rd;
          have_prev <= 1'b1;
          pos       <= pos + LW'(1);
          logical   <= logical + FW'(1);
          state     <= S_RUNR;
        end
        S_QRY: begin
          if (req.mode == MODE_QIDX) begin
            rsp.run_index <= req.operand;
            if (ule) begin
              mid   <= CW'(req.operand);
              state <= S_FETCH;
            end else begin
              rsp.status <= ST_RANGE;
              state      <= S_OUT;
            end
          end else begin
            lo    <= '0;
            hi    <= nruns;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lo == hi) begin
            mid   <= (lo == '0) ? '0 : lo - CW'(1);
            state <= S_FETCH;
          end else begin
            mid   <= mid_c;
            st_rd <= st_mem[mid_c[TW-1:0]];
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (ule) lo <= mid + CW'(1);
          else     hi <= mid;
          state <= S_SRCH;
        end
        S_FETCH: begin
          st_rd <= st_mem[mid[TW-1:0]];
          lf_rd <= lf_mem[mid[TW-1:0]];
          state <= S_FOUT;
        end
        S_FOUT: begin
          rsp.run_index <= FW'(mid);
          rsp.run_start <= st_rd;
          rsp.lf_value  <= lf_rd;
          state         <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/bwtlf_check.sv
// Port-level checker for the run-length LF index core, bound to the top level.
// Depends on bwtlf_pkg.
module bwtlf_check import bwtlf_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input rsp_t out_data,
  input logic cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken while result pending");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !in_stall)
    else $error("config open while busy");
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken at once");
  a_st: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status");
endmodule

bind bwt_run_lf_index_core bwtlf_check u_check (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
  .cfg_ready(cfg_ready)
);
